// File: design/pxrep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pixel replication upscaler.
// Used by the front, queue, back and top modules; depends on nothing.
package pxrep_pkg;

	localparam int SCALE_W   = 5;
	localparam int WIDTH_W   = 11;
	localparam int CFG_W     = 11;
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 3 * CHAN_W;
	localparam int PAD_W     = 2;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QLVL_W      = 3;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1;

	localparam logic OP_PIXEL  = 1'b0;
	localparam logic OP_REPLAY = 1'b1;

	localparam logic CFG_SCALE = 1'b0;
	localparam logic CFG_WIDTH = 1'b1;

	// One queued run: a pixel to be sent run_last+1 times.
	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic               refused;
		logic               row_end;
		logic [PAD_W-1:0]   pad;
		logic [SCALE_W-1:0] run_last;
	} run_cmd_t;

endpackage

// File: design/pxrep_queue.sv
`timescale 1ns / 1ps
// Short register queue of run commands between the front and back parts.
// Depends on pxrep_pkg.
module pxrep_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  pxrep_pkg::run_cmd_t            push_cmd,
	input  logic                           pop,
	output pxrep_pkg::run_cmd_t            head,
	output logic                           not_empty,
	output logic [pxrep_pkg::QLVL_W-1:0]   level
);

	pxrep_pkg::run_cmd_t            entry_q [pxrep_pkg::QUEUE_DEPTH];
	logic [pxrep_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [pxrep_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [pxrep_pkg::QLVL_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign level     = count_q;

endmodule

// File: design/pxrep_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, checks their turn, keeps the row state and line store,
// and issues one run command per item. Depends on pxrep_pkg.
module pxrep_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [pxrep_pkg::SCALE_W-1:0]       scale_q,
	input  logic [pxrep_pkg::WIDTH_W-1:0]       width_q,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [pxrep_pkg::PIX_W-1:0]         in_pixel,
	input  logic [pxrep_pkg::QLVL_W-1:0]        q_level,
	output logic                                push,
	output pxrep_pkg::run_cmd_t                 push_cmd
);

	localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W     = ((CW > pxrep_pkg::WIDTH_W) ? CW : pxrep_pkg::WIDTH_W) + 1;
	localparam int SCALE_CAP = (MAX_SCALE > 31) ? 31 : MAX_SCALE;
	localparam int WIDTH_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

	logic [pxrep_pkg::PIX_W-1:0]   line_mem [MAX_WIDTH];
	logic [pxrep_pkg::PIX_W-1:0]   rd_data_q;

	logic [CW-1:0]                 fill_col_q;
	logic [CW-1:0]                 replay_col_q;
	logic [pxrep_pkg::SCALE_W-1:0] copies_q;

	logic                          valid_s1;
	logic                          refused_s1;
	logic                          replay_s1;
	logic                          row_end_s1;
	logic [pxrep_pkg::PAD_W-1:0]   pad_s1;
	logic [pxrep_pkg::SCALE_W-1:0] run_last_s1;
	logic [pxrep_pkg::PIX_W-1:0]   pix_s1;

	logic [pxrep_pkg::SCALE_W-1:0] eff_scale;
	logic [pxrep_pkg::WIDTH_W-1:0] eff_width;
	logic                          accept;
	logic                          in_fill;
	logic                          refuse;
	logic [CW-1:0]                 col;
	logic                          row_end;
	logic [3:0]                    low_prod;
	logic [pxrep_pkg::PAD_W-1:0]   row_mod;
	logic [pxrep_pkg::PAD_W-1:0]   pad;

	always_comb begin
		if (scale_q == '0)
			eff_scale = pxrep_pkg::SCALE_W'(1);
		else if ({1'b0, scale_q} > (pxrep_pkg::SCALE_W + 1)'(SCALE_CAP))
			eff_scale = pxrep_pkg::SCALE_W'(SCALE_CAP);
		else
			eff_scale = scale_q;
		if (width_q == '0)
			eff_width = pxrep_pkg::WIDTH_W'(1);
		else if ({1'b0, width_q} > (pxrep_pkg::WIDTH_W + 1)'(WIDTH_CAP))
			eff_width = pxrep_pkg::WIDTH_W'(WIDTH_CAP);
		else
			eff_width = width_q;
	end

	assign in_ready = ({1'b0, q_level} + {{pxrep_pkg::QLVL_W{1'b0}}, valid_s1})
		< (pxrep_pkg::QLVL_W + 1)'(pxrep_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign in_fill  = (copies_q == '0);
	assign refuse   = (operation == pxrep_pkg::OP_PIXEL) != in_fill;
	assign col      = in_fill ? fill_col_q : replay_col_q;
	assign row_end  = (CMP_W'(col) + CMP_W'(1)) >= CMP_W'(eff_width);

	// Row length in bytes is width * scale * 3; only its value modulo four matters.
	assign low_prod = eff_width[1:0] * eff_scale[1:0];
	assign row_mod  = low_prod[1:0] + {low_prod[0], 1'b0};
	assign pad      = pxrep_pkg::PAD_W'(0) - row_mod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_col_q   <= '0;
			replay_col_q <= '0;
			copies_q     <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && !refuse) begin
				if (in_fill) begin
					if (row_end) begin
						fill_col_q   <= '0;
						replay_col_q <= '0;
						copies_q     <= eff_scale - 1'b1;
					end else begin
						fill_col_q <= fill_col_q + 1'b1;
					end
				end else begin
					if (row_end) begin
						replay_col_q <= '0;
						copies_q     <= copies_q - 1'b1;
					end else begin
						replay_col_q <= replay_col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			refused_s1  <= refuse;
			replay_s1   <= !refuse && !in_fill;
			row_end_s1  <= !refuse && row_end;
			pad_s1      <= (!refuse && row_end) ? pad : '0;
			run_last_s1 <= refuse ? '0 : eff_scale - 1'b1;
			pix_s1      <= refuse ? '0 : in_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !refuse && in_fill) line_mem[fill_col_q] <= in_pixel;
		if (accept && !refuse && !in_fill) rd_data_q <= line_mem[replay_col_q];
	end

	always_comb begin
		push     = valid_s1;
		{push_cmd.red, push_cmd.green, push_cmd.blue} = replay_s1 ? rd_data_q : pix_s1;
		push_cmd.refused  = refused_s1;
		push_cmd.row_end  = row_end_s1;
		push_cmd.pad      = pad_s1;
		push_cmd.run_last = run_last_s1;
	end

endmodule

// File: design/pxrep_back.sv
`timescale 1ns / 1ps
// Back part: expands each queued run into output beats through an output register.
// Depends on pxrep_pkg.
module pxrep_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pxrep_pkg::run_cmd_t                  head,
	input  logic                                 not_empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pxrep_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [pxrep_pkg::OUT_USER_W-1:0]     out_user,
	output logic                                 out_last
);

	pxrep_pkg::run_cmd_t           cur_q;
	logic                          cur_valid_q;
	logic [pxrep_pkg::SCALE_W-1:0] beat_q;
	logic                          out_valid_q;
	logic [pxrep_pkg::OUT_DATA_W-1:0] data_q;
	logic [pxrep_pkg::OUT_USER_W-1:0] user_q;
	logic                          last_q;

	logic                          load;
	logic                          emit;
	pxrep_pkg::run_cmd_t           cmd;
	logic [pxrep_pkg::SCALE_W-1:0] beat;
	logic                          beat_last;

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !cur_valid_q && not_empty;
	assign emit      = load && (cur_valid_q || not_empty);
	assign cmd       = cur_valid_q ? cur_q : head;
	assign beat      = cur_valid_q ? beat_q : '0;
	assign beat_last = (beat == cmd.run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= emit;
			if (emit) cur_valid_q <= !beat_last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (emit) begin
			beat_q <= beat + 1'b1;
			data_q <= {{(pxrep_pkg::OUT_DATA_W - pxrep_pkg::PIX_W - pxrep_pkg::PAD_W){1'b0}},
				(beat_last ? cmd.pad : 2'b00), cmd.red, cmd.green, cmd.blue};
			user_q <= {cmd.refused, beat_last && cmd.row_end};
			last_q <= beat_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

endmodule

// File: design/pixel_replication_upscaler_top.sv
`timescale 1ns / 1ps
// Top level of the pixel replication upscaler: configuration registers, front,
// run queue and back. Depends on pxrep_pkg, pxrep_front, pxrep_queue and pxrep_back.
//
// Usage: write scale_factor (index 0) and input_width (index 1) on the cfg port
// while the block is idle. Send pixels on the slave stream with tuser low, one
// input row at a time; each pixel comes out scale times on the master stream.
// After a row, send replay beats with tuser high, one per buffered pixel, for the
// remaining scale-1 copies of the row. A beat out of turn gives one refused beat.
// The last beat of each run carries tlast; the last pixel of an output row carries
// row_end and the zero pad count that completes a four-byte row.
// An accepted input beat passes the front stage register, the run queue and the
// output register before its first output beat. The back sends one beat per cycle
// while the receiver is ready, so an item gives scale beats (one if refused); the
// input side takes a new beat every cycle while the four-entry run queue has room.
// Reset clears the row counters and the queue and sets scale and width to one;
// the line store holds no data until written. When the receiver stalls, the
// output register holds its beat, the queue fills, and then tready drops.
module pixel_replication_upscaler_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [pxrep_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// in_blue, in_green, in_red
	input  logic [pxrep_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// operation
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// out_blue, out_green, out_red, pad_bytes, zero fill
	output logic [pxrep_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// row_end, refused
	output logic [pxrep_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                 m_axis_tlast
);

	logic [pxrep_pkg::SCALE_W-1:0] scale_q;
	logic [pxrep_pkg::WIDTH_W-1:0] width_q;

	logic                          push;
	pxrep_pkg::run_cmd_t           push_cmd;
	logic                          pop;
	pxrep_pkg::run_cmd_t           head;
	logic                          not_empty;
	logic [pxrep_pkg::QLVL_W-1:0]  q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= pxrep_pkg::SCALE_RESET;
			width_q <= pxrep_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pxrep_pkg::CFG_SCALE: scale_q <= cfg_data[pxrep_pkg::SCALE_W-1:0];
				pxrep_pkg::CFG_WIDTH: width_q <= cfg_data[pxrep_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	pxrep_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.scale_q  (scale_q),
		.width_q  (width_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.operation(s_axis_tuser),
		.in_pixel ({s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]}),
		.q_level  (q_level),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pxrep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.level    (q_level)
	);

	pxrep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

	a_refused_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("refused beat without tlast or with row_end");

	a_pad_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[25:24] != 2'b00) |-> m_axis_tuser[0])
		else $error("pad bytes outside a row end");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> q_level < pxrep_pkg::QLVL_W'(pxrep_pkg::QUEUE_DEPTH))
		else $error("run queue overflow");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty run queue");

endmodule
